[src/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
// No dependencies; imported by the divider and the top level.
package fbpa_pkg;

  // field and register widths fixed by the interface
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned POOL_W   = 9;
  localparam int unsigned BASE_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;

  // register reset values
  localparam logic [BYTES_W-1:0] BYTES_RESET = 16'd64;
  localparam logic [POOL_W-1:0]  POOL_RESET  = 9'd256;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 32'd0;

  // register indexes on the config port (word address)
  localparam logic [1:0] REG_BLOCK_BYTES  = 2'd0;
  localparam logic [1:0] REG_POOL_BLOCKS  = 2'd1;
  localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_RANGE     = 3'd3,
    ST_DOUBLE    = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  // tag on top of each link table entry
  typedef enum logic [1:0] {
    LNK_NEXT  = 2'b00,
    LNK_END   = 2'b01,
    LNK_TAKEN = 2'b10
  } link_tag_t;

  // divider status back to the controller
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

[src/fbpa_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read; no dependencies.
module fbpa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on fbpa_pkg for the status struct.
module fbpa_div import fbpa_pkg::*; #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  // one trial subtraction per cycle
  always_comb begin
    trial     = {rem_r, num_r[NUM_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = trial >= {1'b0, den_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below den, so the low bits hold it
      rem_nxt = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      num_nxt = {num_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);
  assign quot          = num_r;

endmodule

[src/fixed_block_pool_allocator_unit.sv]
// Top level of the fixed block pool allocator: control, config registers, free list.
// Depends on fbpa_pkg, fbpa_ram (link table) and fbpa_div (release offset divider).
//
//   channel | direction | handshake           | words
//   in      | input     | in_valid/in_ready   | in_opcode, in_block_addr
//   out     | output    | out_valid/out_ready | out_status, out_granted_addr, out_free_blocks
//   cfg     | input     | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// allocate: S_ALOOK takes the link table read, then S_DONE; an empty pool skips to S_DONE.
// release: S_DIV waits for the one-bit-per-cycle divider, then S_RLOOK reads the link table;
// a release that fails before the link table read goes from S_DIV straight to S_DONE.
// one word in flight; the next word is taken while a result waits in the output register.
// reset and a pool_blocks write rebuild the free chain at once: a fill count marks
// the link entries never written, which read as their initial chain link.
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [BASE_W-1:0]   in_block_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [BASE_W-1:0]   out_granted_addr,
  output logic [POOL_W-1:0]   out_free_blocks,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned IW   = $clog2(MAX_BLOCKS);
  localparam int unsigned LW   = IW + 2;
  localparam int unsigned FW   = IW + 1;
  localparam int unsigned AW   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int unsigned MAXC = (MAX_BLOCKS > 511) ? 511 : MAX_BLOCKS;
  localparam int unsigned CW   = (FW > POOL_W) ? FW : POOL_W;
  localparam int unsigned PW   = IW + BYTES_W;
  localparam logic [POOL_W-1:0] MAX_CAP = POOL_W'(MAXC);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ALOOK,
    S_RLOOK,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [POOL_W-1:0]   pool_r, pool_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic [IW-1:0]       head_r, head_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [POOL_W-1:0]   tally_r, tally_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                neg_r, neg_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [BASE_W-1:0]   res_granted_r, res_granted_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [BASE_W-1:0]   out_granted_r, out_granted_nxt;
  logic [POOL_W-1:0]   out_free_r, out_free_nxt;

  logic [BYTES_W-1:0]  eff_bytes;
  logic [POOL_W-1:0]   n_eff;
  logic [POOL_W-1:0]   n_wr;
  logic                in_fire;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  logic [AW-1:0]       addr_m;
  logic [AW-1:0]       base_m;
  logic                addr_below;
  logic [AW-1:0]       diff;
  logic [CW-1:0]       next_ext;
  logic [LW-1:0]       virgin;
  logic [LW-1:0]       link_rd;
  link_tag_t           link_tag;
  logic [IW-1:0]       link_idx;
  logic [PW-1:0]       prod;
  logic [BASE_W-1:0]   sum;
  logic                quot_big;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [LW-1:0]       ram_wdata;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  logic [LW-1:0]       ram_rdata;

  logic                div_start;
  div_stat_t           div_stat;
  logic [AW-1:0]       div_quot;

  // link table
  fbpa_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // offset divided by block size on release
  fbpa_div #(
    .NUM_W (AW),
    .DEN_W (BYTES_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (diff),
    .den   (eff_bytes),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // effective configuration and handshakes
  always_comb begin
    eff_bytes = (bytes_r == '0) ? BYTES_W'(1) : bytes_r;
    n_eff     = (pool_r > MAX_CAP) ? MAX_CAP : pool_r;
    n_wr      = (pwdata[POOL_W-1:0] > MAX_CAP) ? MAX_CAP : pwdata[POOL_W-1:0];
    in_fire   = in_valid && in_ready;
    cfg_wr    = psel && penable && pwrite;
    cfg_idx   = paddr[3:2];
  end

  // release offset from base, either direction
  always_comb begin
    addr_m     = in_block_addr[AW-1:0];
    base_m     = base_r[AW-1:0];
    addr_below = addr_m < base_m;
    diff       = addr_below ? (base_m - addr_m) : (addr_m - base_m);
    div_start  = in_fire && (opcode_t'(in_opcode) == OP_RELEASE);
    quot_big   = div_quot >= AW'(n_eff);
  end

  // link entry at idx_r; entries at or above the fill count were never written
  always_comb begin
    next_ext = CW'(idx_r) + CW'(1);
    if (next_ext < CW'(n_eff)) begin
      virgin = {LNK_NEXT, next_ext[IW-1:0]};
    end else begin
      virgin = {LNK_END, IW'(0)};
    end
    link_rd  = (FW'(idx_r) < fill_r) ? ram_rdata : virgin;
    link_tag = link_tag_t'(link_rd[LW-1:IW]);
    link_idx = link_rd[IW-1:0];
  end

  // granted address for the popped block
  always_comb begin
    prod = PW'(idx_r) * PW'(eff_bytes);
    sum  = base_r + BASE_W'(prod);
  end

  // memory ports; reads and writes fall in different states, so no overlap
  always_comb begin
    ram_raddr = (state_r == S_IDLE) ? head_r : div_quot[IW-1:0];
    ram_re    = (in_fire && (opcode_t'(in_opcode) == OP_ALLOC) && head_valid_r) ||
                ((state_r == S_DIV) && div_stat.done && div_stat.rem_zero &&
                 !neg_r && !quot_big);
    ram_waddr = idx_r;
    ram_we    = (state_r == S_ALOOK) ||
                ((state_r == S_RLOOK) && (link_tag == LNK_TAKEN));
    if (state_r == S_ALOOK) begin
      ram_wdata = {LNK_TAKEN, IW'(0)};
    end else if (head_valid_r) begin
      ram_wdata = {LNK_NEXT, head_r};
    end else begin
      ram_wdata = {LNK_END, head_r};
    end
  end

  // sequencer and free list bookkeeping
  always_comb begin
    state_nxt       = state_r;
    bytes_nxt       = bytes_r;
    pool_nxt        = pool_r;
    base_nxt        = base_r;
    head_nxt        = head_r;
    head_valid_nxt  = head_valid_r;
    tally_nxt       = tally_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    neg_nxt         = neg_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_free_nxt    = out_free_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_granted_nxt = '0;
          if (opcode_t'(in_opcode) == OP_ALLOC) begin
            if (head_valid_r) begin
              idx_nxt   = head_r;
              state_nxt = S_ALOOK;
            end else begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end
          end else begin
            neg_nxt   = addr_below;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (!div_stat.rem_zero) begin
            res_status_nxt = ST_UNALIGNED;
            state_nxt      = S_DONE;
          end else if (neg_r || quot_big) begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt   = div_quot[IW-1:0];
            state_nxt = S_RLOOK;
          end
        end
      end
      S_ALOOK: begin
        // pop the head; a never-written head is the next one in fill order
        head_nxt        = link_idx;
        head_valid_nxt  = (link_tag == LNK_NEXT);
        tally_nxt       = tally_r - POOL_W'(1);
        if (FW'(idx_r) == fill_r) begin
          fill_nxt = fill_r + FW'(1);
        end
        res_status_nxt  = ST_OK;
        res_granted_nxt = BASE_W'(sum[AW-1:0]);
        state_nxt       = S_DONE;
      end
      S_RLOOK: begin
        // push the released block, unless it is already free
        if (link_tag == LNK_TAKEN) begin
          head_nxt       = idx_r;
          head_valid_nxt = 1'b1;
          tally_nxt      = tally_r + POOL_W'(1);
          res_status_nxt = ST_OK;
        end else begin
          res_status_nxt = ST_DOUBLE;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          out_free_nxt    = tally_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes; a pool size write rebuilds the chain
    if (cfg_wr) begin
      case (cfg_idx)
        REG_BLOCK_BYTES: begin
          bytes_nxt = pwdata[BYTES_W-1:0];
        end
        REG_POOL_BLOCKS: begin
          pool_nxt       = pwdata[POOL_W-1:0];
          head_nxt       = '0;
          head_valid_nxt = (n_wr != '0);
          tally_nxt      = n_wr;
          fill_nxt       = '0;
        end
        REG_BASE_ADDRESS: begin
          base_nxt = pwdata[BASE_W-1:0];
        end
        default: begin
          bytes_nxt = bytes_r;
        end
      endcase
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bytes_r      <= BYTES_RESET;
      pool_r       <= POOL_RESET;
      base_r       <= BASE_RESET;
      head_r       <= '0;
      head_valid_r <= (MAX_CAP != '0);
      tally_r      <= (POOL_RESET > MAX_CAP) ? MAX_CAP : POOL_RESET;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bytes_r      <= bytes_nxt;
      pool_r       <= pool_nxt;
      base_r       <= base_nxt;
      head_r       <= head_nxt;
      head_valid_r <= head_valid_nxt;
      tally_r      <= tally_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    neg_r         <= neg_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_free_r    <= out_free_nxt;
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      REG_BLOCK_BYTES:  prdata = DATA_W'(bytes_r);
      REG_POOL_BLOCKS:  prdata = DATA_W'(pool_r);
      REG_BASE_ADDRESS: prdata = DATA_W'(base_r);
      default:          prdata = '0;
    endcase
  end

  assign pready           = 1'b1;
  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_addr = out_granted_r;
  assign out_free_blocks  = out_free_r;

  // head is valid exactly when some block is free
  a_head_tally: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r == (tally_r != '0))
    else $error("free head and free count disagree");

  // free count never exceeds the pool
  a_tally_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= n_eff)
    else $error("free count above pool size");

  // fill count never runs past the pool
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= CW'(n_eff))
    else $error("fill count above pool size");

  // link table is never read and written in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("link table read and write overlap");

  // a divider result only arrives while a release waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider result outside release");

endmodule
